// File: src/ms_pkg.sv
// Package for the merge sorter: default sizes and the sequencer state type.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package ms_pkg;

  localparam int unsigned MAX_ITEMS_DEF   = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_READ  = 6'b000100,
    ST_CMP   = 6'b001000,
    ST_OUTRD = 6'b010000,
    ST_OUTEM = 6'b100000
  } ms_state_e;

endpackage

`default_nettype wire

// File: src/ms_ram.sv
// Word store for the merge sorter: one write port, two registered read ports.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ms_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

`default_nettype wire

// File: src/merge_sorter.sv
// Merge sorter: loads a set of signed words one per cycle, then sorts them
// bottom-up with one shared comparator and two ping-pong stores.
// After the last word: ceil(log2 n) merge passes, each run set up once and
// each word read then compared; then the n results go out smallest first.
// Reset clears the sequencer, count, overflow flag and result valid flag;
// store contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module merge_sorter #(
  parameter int unsigned MAX_ITEMS   = ms_pkg::MAX_ITEMS_DEF,
  parameter int unsigned VALUE_WIDTH = ms_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [VALUE_WIDTH-1:0] value_i,
  input  wire logic                          last_i,
  output logic                               result_valid_o,
  output logic signed      [VALUE_WIDTH-1:0] sorted_value_o,
  output logic                               final_res_o,
  output logic                               overflow_o
);

  import ms_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned NW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CW = $clog2(MAX_ITEMS) + 2;

  ms_state_e state_q, state_d;
  logic [NW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          src_b_q, src_b_d;
  logic [CW-1:0] lo_q, lo_d, width_q, width_d, mid_q, mid_d, hi_q, hi_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic          res_valid_q, res_valid_d;
  logic [VALUE_WIDTH-1:0] res_value_q, res_value_d;
  logic          res_final_q, res_final_d, res_ovf_q, res_ovf_d;

  logic [CW-1:0] n_ext, sum1, sum2, width2;
  logic          accept, take_first;
  logic [VALUE_WIDTH-1:0] a_rd0, a_rd1, b_rd0, b_rd1, src0, src1, merge_word;
  logic [VALUE_WIDTH-1:0] wdata_a;
  logic [AW-1:0] waddr_a, raddr0, raddr1;
  logic          we_a, we_b;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign n_ext  = CW'(count_q);
  assign sum1   = lo_q + width_q;
  assign width2 = width_q << 1;
  assign sum2   = lo_q + width2;

  assign src0       = src_b_q ? b_rd0 : a_rd0;
  assign src1       = src_b_q ? b_rd1 : a_rd1;
  assign take_first = (i_q < mid_q) &&
                      ((j_q >= hi_q) || ($signed(src0) < $signed(src1)));
  assign merge_word = take_first ? src0 : src1;

  assign raddr0  = (state_q == ST_OUTRD) ? k_q[AW-1:0] : i_q[AW-1:0];
  assign raddr1  = j_q[AW-1:0];
  assign waddr_a = (state_q == ST_IDLE) ? count_q[AW-1:0] : k_q[AW-1:0];
  assign wdata_a = (state_q == ST_IDLE) ? value_i : merge_word;

  ms_ram #(.DEPTH(MAX_ITEMS), .WIDTH(VALUE_WIDTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr_a),
    .wdata_i (wdata_a),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(a_rd0),
    .rdata1_o(a_rd1)
  );

  ms_ram #(.DEPTH(MAX_ITEMS), .WIDTH(VALUE_WIDTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (k_q[AW-1:0]),
    .wdata_i (merge_word),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(b_rd0),
    .rdata1_o(b_rd1)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    src_b_d     = src_b_q;
    lo_d        = lo_q;
    width_d     = width_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    res_valid_d = 1'b0;
    res_value_d = res_value_q;
    res_final_d = res_final_q;
    res_ovf_d   = res_ovf_q;
    we_a        = 1'b0;
    we_b        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (count_q < NW'(MAX_ITEMS)) begin
            we_a    = 1'b1;
            count_d = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            src_b_d = 1'b0;
            lo_d    = '0;
            width_d = CW'(1);
            k_d     = '0;
            state_d = (count_d == NW'(1)) ? ST_OUTRD : ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        mid_d   = (sum1 < n_ext) ? sum1 : n_ext;
        hi_d    = (sum2 < n_ext) ? sum2 : n_ext;
        i_d     = lo_q;
        j_d     = (sum1 < n_ext) ? sum1 : n_ext;
        k_d     = lo_q;
        state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (src_b_q) begin
          we_a = 1'b1;
        end else begin
          we_b = 1'b1;
        end
        if (take_first) begin
          i_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
        k_d     = k_q + 1'b1;
        state_d = ST_READ;
        if (k_d == hi_q) begin
          if (sum2 >= n_ext) begin
            width_d = width2;
            src_b_d = !src_b_q;
            if (width2 >= n_ext) begin
              k_d     = '0;
              state_d = ST_OUTRD;
            end else begin
              lo_d    = '0;
              state_d = ST_SETUP;
            end
          end else begin
            lo_d    = sum2;
            state_d = ST_SETUP;
          end
        end
      end
      ST_OUTRD: begin
        state_d = ST_OUTEM;
      end
      ST_OUTEM: begin
        res_valid_d = 1'b1;
        res_value_d = src0;
        res_final_d = ((k_q + 1'b1) == n_ext);
        res_ovf_d   = ovf_q;
        k_d         = k_q + 1'b1;
        if ((k_q + 1'b1) == n_ext) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_OUTRD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      src_b_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      src_b_q     <= src_b_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    width_q     <= width_d;
    mid_q       <= mid_d;
    hi_q        <= hi_d;
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    res_value_q <= res_value_d;
    res_final_q <= res_final_d;
    res_ovf_q   <= res_ovf_d;
  end

  assign result_valid_o = res_valid_q;
  assign sorted_value_o = res_value_q;
  assign final_res_o    = res_final_q;
  assign overflow_o     = res_ovf_q;

endmodule

`default_nettype wire

// File: src/ms_checker.sv
// Port-level checks for the merge sorter, bound to the top level.
// Depends on merge_sorter.
`timescale 1ns / 1ps
`default_nettype none

module ms_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic last_i,
  input wire logic result_valid_o,
  input wire logic final_res_o
);

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_i |=> busy)
    else $error("last word did not start the sort");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !last_i |=> !busy)
    else $error("busy after a non-last word");

  a_idle_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !busy |-> final_res_o)
    else $error("result word while idle that is not final");

  a_fell_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o && final_res_o)
    else $error("busy dropped without a final word");

  a_final_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && final_res_o |=> !result_valid_o)
    else $error("result word straight after the final one");

endmodule

bind merge_sorter ms_checker u_ms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .last_i        (last_i),
  .result_valid_o(result_valid_o),
  .final_res_o   (final_res_o)
);

`default_nettype wire
